// ===== hw/rtl/ksb_pkg.sv =====
// Shared types, widths and helpers for the knapsack best-value block.
// No dependencies; imported by ksb_table, ksb_ctrl and knapsack_best_value.
package ksb_pkg;

    localparam int DEF_MAX_CAPACITY = 1023;
    localparam int DEF_VALUE_BITS   = 16;

    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 10;
    localparam int CAP_W    = 10;
    localparam int ENTRY_W  = 32;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DRAIN,
        ST_READ,
        ST_RESULT
    } t_state;

    // Add an item value to a table entry, saturating at the entry width
    function automatic logic [ENTRY_W-1:0] sat_add(
        input logic [ENTRY_W-1:0] a,
        input logic [VALUE_W-1:0] b
    );
        logic [ENTRY_W:0] s;
        s = {1'b0, a} + (ENTRY_W + 1)'(b);
        return s[ENTRY_W] ? {ENTRY_W{1'b1}} : s[ENTRY_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ksb_table.sv =====
// Best-value table: one write port, two registered read ports.
// Depends on ksb_pkg for the entry width.
module ksb_table #(
    parameter int DEPTH = ksb_pkg::DEF_MAX_CAPACITY + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [ksb_pkg::ENTRY_W-1:0] i_wr_data,
    input  logic [AW-1:0]               i_rd_addr_a,
    input  logic [AW-1:0]               i_rd_addr_b,
    output logic [ksb_pkg::ENTRY_W-1:0] o_rd_data_a,
    output logic [ksb_pkg::ENTRY_W-1:0] o_rd_data_b
);
    import ksb_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    // Write one entry, read two entries through registered outputs
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ===== hw/rtl/ksb_ctrl.sv =====
// Sequencer for the knapsack table: update pass, readout and clearing sweep.
// Depends on ksb_pkg; drives the ports of ksb_table.
module ksb_ctrl #(
    parameter int MAX_CAPACITY = ksb_pkg::DEF_MAX_CAPACITY,
    parameter int VALUE_BITS   = ksb_pkg::DEF_VALUE_BITS,
    parameter int AW           = $clog2(MAX_CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [ksb_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [ksb_pkg::WEIGHT_W-1:0] i_item_weight,
    input  logic                         i_last_item,
    input  logic [ksb_pkg::CAP_W-1:0]    i_capacity,
    output logic                         o_strobe,
    output logic [ksb_pkg::ENTRY_W-1:0]  o_best_value,
    output logic                         o_we,
    output logic [AW-1:0]                o_wr_addr,
    output logic [ksb_pkg::ENTRY_W-1:0]  o_wr_data,
    output logic [AW-1:0]                o_rd_addr_a,
    output logic [AW-1:0]                o_rd_addr_b,
    input  logic [ksb_pkg::ENTRY_W-1:0]  i_rd_data_a,
    input  logic [ksb_pkg::ENTRY_W-1:0]  i_rd_data_b
);
    import ksb_pkg::*;

    localparam int CMP_W = (AW > WEIGHT_W) ? AW : WEIGHT_W;
    localparam logic [CMP_W-1:0] MAX_EXT  = CMP_W'(MAX_CAPACITY);
    localparam logic [AW-1:0]    MAX_ADDR = AW'(MAX_CAPACITY);
    localparam logic [VALUE_W-1:0] VAL_MASK = (VALUE_BITS >= VALUE_W) ?
        {VALUE_W{1'b1}} : VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

    t_state r_state, n_state;

    logic [AW-1:0]      r_c, n_c;
    logic [AW-1:0]      r_lo, n_lo;
    logic [AW-1:0]      r_w, n_w;
    logic [VALUE_W-1:0] r_val, n_val;
    logic               r_last, n_last;
    logic               r_rd_pend, n_rd_pend;
    logic [AW-1:0]      r_wa, n_wa;

    logic               accept;
    logic [CMP_W-1:0]   w_ext;
    logic [CMP_W-1:0]   lo_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic [AW-1:0]      cap_addr;
    logic [ENTRY_W-1:0] take;
    logic [ENTRY_W-1:0] best;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign w_ext   = CMP_W'(i_item_weight);
    assign lo_ext  = (w_ext == '0) ? CMP_W'(1) : w_ext;
    assign cap_ext = CMP_W'(i_capacity);
    // Clamp the readout address to the top entry
    assign cap_addr = (cap_ext > MAX_EXT) ? MAX_ADDR : AW'(cap_ext);

    // Combine the old entry with the entry one weight below
    assign take = sat_add(i_rd_data_b, r_val);
    assign best = (take > i_rd_data_a) ? take : i_rd_data_a;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_c == '0) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (lo_ext > MAX_EXT) ? ST_DRAIN : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (r_c == r_lo) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = r_last ? ST_READ : ST_IDLE;
            end
            ST_READ:   n_state = ST_RESULT;
            ST_RESULT: n_state = ST_CLEAR;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // Counter, item latch and write pipeline
    always_comb begin
        n_c       = r_c;
        n_lo      = r_lo;
        n_w       = r_w;
        n_val     = r_val;
        n_last    = r_last;
        n_wa      = r_c;
        n_rd_pend = (r_state == ST_UPDATE);
        if (accept) begin
            n_c    = MAX_ADDR;
            n_lo   = AW'(lo_ext);
            n_w    = AW'(w_ext);
            n_val  = i_item_value & VAL_MASK;
            n_last = i_last_item;
        end else if (r_state == ST_UPDATE || r_state == ST_CLEAR) begin
            if (r_c != '0) n_c = r_c - AW'(1);
        end else if (r_state == ST_RESULT) begin
            n_c = MAX_ADDR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_c       <= MAX_ADDR;
            r_rd_pend <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_c       <= n_c;
            r_rd_pend <= n_rd_pend;
            r_last    <= n_last;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_w   <= n_w;
        r_val <= n_val;
        r_wa  <= n_wa;
    end

    // Outputs and memory port drive
    always_comb begin
        o_busy       = (r_state != ST_IDLE);
        o_strobe     = (r_state == ST_RESULT);
        o_best_value = i_rd_data_a;
        o_rd_addr_a  = (r_state == ST_READ) ? cap_addr : r_c;
        o_rd_addr_b  = r_c - r_w;
        o_we         = r_rd_pend || (r_state == ST_CLEAR);
        o_wr_addr    = (r_state == ST_CLEAR) ? r_c : r_wa;
        o_wr_data    = (r_state == ST_CLEAR) ? '0 : best;
    end

`ifndef NO_ASSERTIONS
    // Update writes never touch entry zero
    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_wa != '0))
        else $error("update wrote entry zero");

    // Update writes never lower an entry
    a_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (o_wr_data >= i_rd_data_a))
        else $error("update lowered an entry");

    // A result is followed by the clearing sweep
    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (r_state == ST_CLEAR) && (r_c == MAX_ADDR))
        else $error("no clearing sweep after result");

    // An accepted transfer always makes the block busy
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item left block idle");
`endif

endmodule

// ===== hw/rtl/knapsack_best_value.sv =====
// Top level of the knapsack best-value block; depends on ksb_pkg, ksb_ctrl and ksb_table.
// Each item updates one table entry per cycle, from the top entry down to entry max(w,1),
// then passes a write drain state before the next item is accepted; a last item adds a
// read state, a result state and a clearing sweep of the whole table.
// The result strobe is high for one cycle and the receiver cannot stall it.
// Reset: synchronous, active low; busy stays high through the clear of all table entries.
module knapsack_best_value #(
    parameter int MAX_CAPACITY = ksb_pkg::DEF_MAX_CAPACITY,
    parameter int VALUE_BITS   = ksb_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ksb_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [ksb_pkg::WEIGHT_W-1:0] i_item_weight,
    input  logic                         i_last_item,
    output logic                         o_strobe,
    output logic [ksb_pkg::ENTRY_W-1:0]  o_best_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ksb_pkg::CAP_W-1:0]    i_cfg_data
);
    import ksb_pkg::*;

    localparam int AW = $clog2(MAX_CAPACITY + 1);

    logic [CAP_W-1:0]   r_capacity;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;
    logic [ENTRY_W-1:0] rd_data_a;
    logic [ENTRY_W-1:0] rd_data_b;

    // Take a capacity write on every transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    ksb_ctrl #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .VALUE_BITS   (VALUE_BITS),
        .AW           (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_item_value  (i_item_value),
        .i_item_weight (i_item_weight),
        .i_last_item   (i_last_item),
        .i_capacity    (r_capacity),
        .o_strobe      (o_strobe),
        .o_best_value  (o_best_value),
        .o_we          (we),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_addr_a   (rd_addr_a),
        .o_rd_addr_b   (rd_addr_b),
        .i_rd_data_a   (rd_data_a),
        .i_rd_data_b   (rd_data_b)
    );

    ksb_table #(
        .DEPTH (MAX_CAPACITY + 1),
        .AW    (AW)
    ) u_table (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for knapsack_best_value: a directed table of problems, then random ones.
// Depends on ksb_pkg and the knapsack_best_value RTL; expected answers come from a local DP table.
module tb;
    import ksb_pkg::*;

    localparam int MAX_CAP       = DEF_MAX_CAPACITY;
    localparam int VAL_BITS      = DEF_VALUE_BITS;
    localparam int RANDOM_ITEMS  = 580;
    // Idle time that lets an item pass or a post-result clear finish
    localparam int SETTLE_CYCLES = MAX_CAP + 80;
    localparam longint TIMEOUT_NS = 64'd60_000_000;
    localparam logic [ENTRY_W-1:0] VALUE_MASK =
        (VAL_BITS >= 32) ? '1 : ENTRY_W'((64'd1 << VAL_BITS) - 64'd1);

    typedef enum {ROW_CAP, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [CAP_W-1:0]    cap;
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;
        bit                  last;
        bit                  typed;
        logic [ENTRY_W-1:0]  want;
    } t_row;

    localparam int DIR_ROWS = 27;

    // Directed problems; typed answers only where they are obvious
    t_row dir_rows [DIR_ROWS] = '{
        '{ROW_CAP,  10'd0,     16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'hFFFF,  10'd0,     1'b1, 1'b1, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd0,     10'd0,     1'b1, 1'b1, 32'd0},
        '{ROW_CAP,  10'd1023,  16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'hFFFF,  10'd0,     1'b1, 1'b1, 32'd65535},
        '{ROW_ITEM, 10'd0,     16'hFFFF,  10'd1023,  1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd1,     10'd1,     1'b1, 1'b1, 32'd65535},
        '{ROW_ITEM, 10'd0,     16'd1234,  10'd1023,  1'b0, 1'b0, 32'd0},
        '{ROW_CAP,  10'd5,     16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd77,    10'd6,     1'b1, 1'b1, 32'd0},
        '{ROW_CAP,  10'd10,    16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd10,    10'd5,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd20,    10'd5,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd15,    10'd6,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd1,     10'd0,     1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  10'd1,     16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'hFFFF,  10'd1,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'h5555,  10'h2AA,   1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'hAAAA,  10'h155,   1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  10'h2AA,   16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'hAAAA,  10'h155,   1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'h5555,  10'h155,   1'b1, 1'b0, 32'd0},
        '{ROW_CAP,  10'h155,   16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd300,   10'h155,   1'b1, 1'b1, 32'd300},
        '{ROW_CAP,  10'd1023,  16'd0,     10'd0,     1'b0, 1'b0, 32'd0},
        '{ROW_ITEM, 10'd0,     16'd9,     10'd1022,  1'b1, 1'b1, 32'd9}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic [VALUE_W-1:0]  i_item_value  = '0;
    logic [WEIGHT_W-1:0] i_item_weight = '0;
    logic                i_last_item   = 1'b0;
    logic                o_strobe;
    logic [ENTRY_W-1:0]  o_best_value;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_W-1:0]    i_cfg_data    = '0;

    // Local copy of the DP table and the capacity register
    logic [ENTRY_W-1:0] best_by_cap [0:MAX_CAP];
    logic [CAP_W-1:0]   held_capacity = '0;
    logic [ENTRY_W-1:0] best_expected [$];

    bit sender_idles   = 1'b1;
    int mismatches     = 0;
    int items_accepted = 0;
    int problems_done  = 0;
    int results_seen   = 0;
    int cap_writes     = 0;

    knapsack_best_value DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item_value  (i_item_value),
        .i_item_weight (i_item_weight),
        .i_last_item   (i_last_item),
        .o_strobe      (o_strobe),
        .o_best_value  (o_best_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i <= MAX_CAP; i++) begin
            best_by_cap[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                   input logic [ENTRY_W-1:0] want);
        $display("MISMATCH at %0t: %s, got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Fold one item into the table, high capacity down; on the last item read
    // out best[capacity] and clear the table
    function automatic void solve_item(input logic [VALUE_W-1:0] value,
                                       input logic [WEIGHT_W-1:0] weight, input bit last,
                                       output bit gives, output logic [ENTRY_W-1:0] answer);
        logic [ENTRY_W-1:0] gain;
        logic [ENTRY_W:0]   take;
        int                 lo;
        int                 c;
        int                 cap;
        gain = ENTRY_W'(value) & VALUE_MASK;
        lo = (weight == '0) ? 1 : int'(weight);
        for (c = MAX_CAP; c >= lo; c--) begin
            take = {1'b0, best_by_cap[c - int'(weight)]} + {1'b0, gain};
            if (take[ENTRY_W]) begin
                take[ENTRY_W-1:0] = '1;
            end
            if (take[ENTRY_W-1:0] > best_by_cap[c]) begin
                best_by_cap[c] = take[ENTRY_W-1:0];
            end
        end
        best_by_cap[0] = '0;
        gives = last;
        answer = '0;
        if (last) begin
            cap = (int'(held_capacity) > MAX_CAP) ? MAX_CAP : int'(held_capacity);
            answer = best_by_cap[cap];
            for (c = 0; c <= MAX_CAP; c++) begin
                best_by_cap[c] = '0;
            end
        end
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold start low until every expected answer has come out
    task automatic wait_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (best_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Let a trailing item pass or the post-result clear finish
    task automatic drain_block();
        wait_results();
        idle_cycles(SETTLE_CYCLES);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        while (sender_idles && $urandom_range(0, 99) < 33) begin
            idle_cycles(1);
        end
        @(negedge i_clk);
        start <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        held_capacity = cap;
        cap_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Present one item until it transfers, then predict its answer
    task automatic send_item(input logic [VALUE_W-1:0] value, input logic [WEIGHT_W-1:0] weight,
                             input bit last, input bit typed, input logic [ENTRY_W-1:0] want);
        bit                 taken;
        bit                 gives;
        logic [ENTRY_W-1:0] answer;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if (sender_idles && $urandom_range(0, 99) < 33) begin
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_item_value <= value;
                i_item_weight <= weight;
                i_last_item <= last;
            end
            @(posedge i_clk);
            taken = start && !busy;
        end
        solve_item(value, weight, last, gives, answer);
        if (gives) begin
            best_expected.push_back(typed ? want : answer);
            problems_done++;
        end
        items_accepted++;
    endtask

    // Check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (best_expected.size() == 0) begin
                report_mismatch("result with nothing expected", o_best_value, '0);
            end else begin
                if (o_best_value !== best_expected[0]) begin
                    report_mismatch("best_value", o_best_value, best_expected[0]);
                end
                void'(best_expected.pop_front());
                results_seen++;
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d answers outstanding", best_expected.size());
        $display("knapsack_best_value verification failed");
        $finish;
    end

    initial begin
        int                  sent;
        int                  n;
        int                  k;
        bit                  paused;
        logic [CAP_W-1:0]    cap;
        logic [VALUE_W-1:0]  value;
        logic [WEIGHT_W-1:0] weight;
        sent = 0;
        paused = 1'b0;

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CAP) begin
                drain_block();
                write_capacity(dir_rows[i].cap);
            end else begin
                send_item(dir_rows[i].value, dir_rows[i].weight, dir_rows[i].last,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random problems of a few items each
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 30) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cap = CAP_W'(MAX_CAP);
                    3:       cap = '0;
                    4, 5:    cap = CAP_W'($urandom_range(1, 48));
                    default: cap = CAP_W'($urandom_range(0, MAX_CAP));
                endcase
                drain_block();
                write_capacity(cap);
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                wait_results();
                paused = 1'b1;
            end
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 14);
            for (k = 0; k < n; k++) begin
                sender_idles = !(sent >= 150 && sent < 270);
                if (sender_idles && $urandom_range(0, 99) < 5) begin
                    idle_cycles($urandom_range(1, 2 * MAX_CAP));
                end
                // Move the capacity in the middle of a problem now and then
                if (k > 0 && $urandom_range(0, 99) < 3) begin
                    drain_block();
                    write_capacity(CAP_W'($urandom_range(0, MAX_CAP)));
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: weight = WEIGHT_W'($urandom_range(0, 24));
                    4, 5, 6:    weight = WEIGHT_W'($urandom_range(0, MAX_CAP));
                    7:          weight = $urandom_range(0, 1) ? WEIGHT_W'(MAX_CAP) : '0;
                    default:    weight = WEIGHT_W'($urandom_range(MAX_CAP / 2, MAX_CAP));
                endcase
                case ($urandom_range(0, 9))
                    7, 8:    value = VALUE_W'($urandom_range(0, 31));
                    9:       value = $urandom_range(0, 1) ? '1 : '0;
                    default: value = VALUE_W'($urandom_range(0, 65535));
                endcase
                send_item(value, weight, k == n - 1, 1'b0, '0);
                sent++;
            end
        end
        sender_idles = 1'b1;

        // Drain and allow a stray result to show up
        wait_results();
        idle_cycles(2 * MAX_CAP + 16);

        $display("run covered %0d items in %0d problems, %0d capacity writes",
                 items_accepted, problems_done, cap_writes);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && best_expected.size() == 0) begin
            $display("knapsack_best_value verification clean");
        end else begin
            $display("knapsack_best_value verification failed");
        end
        $finish;
    end

endmodule
